### hdl/rc_serial_frame_receiver_macros.svh
// Assertion macros used by the checker.
`ifndef RC_SERIAL_FRAME_RECEIVER_MACROS_SVH
`define RC_SERIAL_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication.
`define RCSFR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rcsfr assertion failed");

// Next-cycle implication.
`define RCSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rcsfr assertion failed");

`endif

### hdl/rcsfr_pkg.sv
package rcsfr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 16;
   localparam int unsigned POS_W       = 5;
   localparam int unsigned CHAN_W      = 4;
   localparam int unsigned FRAME_WORDS = 16;
   localparam int unsigned WADDR_W     = 4;
   localparam int unsigned STEP_W      = 2;
   localparam int unsigned RSP_DATA_W  = 24;

   localparam logic [POS_W-1:0]  POS_LAST   = 5'd31;
   localparam logic [POS_W-1:0]  SUM_LEN    = 5'd30;
   localparam logic [WORD_W-1:0] SUM_INIT   = 16'hFFFF;
   localparam logic [BYTE_W-1:0] HDR0_RESET = 8'h20;
   localparam logic [BYTE_W-1:0] HDR1_RESET = 8'h40;

   typedef enum logic {
      CSR_HEADER_FIRST  = 1'b0,
      CSR_HEADER_SECOND = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      COND_ALWAYS    = 2'd0,
      COND_FRAME_OK  = 2'd1,
      COND_RSP_FREE  = 2'd2,
      COND_CHAN_LAST = 2'd3
   } cond_type;

   typedef enum logic [STEP_W-1:0] {
      STEP_RX    = 2'd0,
      STEP_WAIT  = 2'd1,
      STEP_LOAD  = 2'd2,
      STEP_SPARE = 2'd3
   } step_type;

   typedef struct packed {
      logic req_ready;
      logic chan_init;
      logic rsp_load;
   } ctl_type;

   typedef struct packed {
      logic frame_ok;
      logic rsp_free;
      logic chan_last;
   } status_type;

   typedef struct packed {
      ctl_type  ctl;
      cond_type cond;
      step_type target_true;
      step_type target_false;
   } ucode_type;

   // Control store: one word per step.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      w = '{ctl: '0, cond: COND_ALWAYS, target_true: STEP_RX, target_false: STEP_RX};
      case (step)
         STEP_RX: begin
            w.ctl.req_ready = 1'b1;
            w.ctl.chan_init = 1'b1;
            w.cond          = COND_FRAME_OK;
            w.target_true   = STEP_WAIT;
            w.target_false  = STEP_RX;
         end
         STEP_WAIT: begin
            w.cond         = COND_RSP_FREE;
            w.target_true  = STEP_LOAD;
            w.target_false = STEP_WAIT;
         end
         STEP_LOAD: begin
            w.ctl.rsp_load = 1'b1;
            w.cond         = COND_CHAN_LAST;
            w.target_true  = STEP_RX;
            w.target_false = STEP_WAIT;
         end
         default: begin
            w.cond = COND_ALWAYS;
         end
      endcase
      return w;
   endfunction

endpackage

### hdl/rc_serial_frame_receiver.sv
// Serial radio-control frame receiver, 14-channel 32-byte frames.
// req_*: one received byte per item; ready while the block is hunting or
//   collecting a frame, one byte per cycle.
// rsp_*: one item per channel word of a frame whose checksum matches,
//   channels 1..CHANNEL_COUNT in order, tlast on the final channel.
// csr_*: index 0 = header_first, index 1 = header_second; always ready.
// A frame is two header bytes, 28 channel bytes and a little-endian
// checksum equal to 0xFFFF minus bytes 0..29. A bad second header byte or
// a checksum mismatch restarts the hunt without output.
// Readout: once the last byte of a good frame is accepted, each channel passes
// through the wait step (wait on the output register) and then the load step
// (load it from the word store); req_tready is low for the whole readout.
// A stalled rsp side holds the readout in its wait step; the last channel
// can sit in the output register while the next frame's bytes come in.
// Reset restores the header defaults (0x20, 0x40) and the hunt state.
module rc_serial_frame_receiver #(
   parameter int unsigned CHANNEL_COUNT = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [3:0] channel_number, [19:4] channel_value, zero
   output logic        rsp_tlast,   // last_channel
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   rcsfr_pkg::ctl_type    ctl;
   rcsfr_pkg::status_type status;

   rcsfr_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .status(status),
      .ctl   (ctl)
   );

   rcsfr_datapath #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .status    (status),
      .req_tvalid(req_tvalid),
      .req_tdata (req_tdata),
      .csr_tvalid(csr_tvalid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   assign req_tready = ctl.req_ready;
   assign csr_tready = 1'b1;

endmodule

### hdl/rcsfr_ram.sv
module rcsfr_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/rcsfr_sequencer.sv
module rcsfr_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  rcsfr_pkg::status_type status,
   output rcsfr_pkg::ctl_type    ctl
);

   rcsfr_pkg::step_type  step_ff;
   rcsfr_pkg::step_type  step_in;
   rcsfr_pkg::ucode_type uword;
   logic                 cond_hit;

   assign uword = rcsfr_pkg::ucode_rom(step_ff);
   assign ctl   = uword.ctl;

   always_comb begin
      case (uword.cond)
         rcsfr_pkg::COND_ALWAYS:    cond_hit = 1'b1;
         rcsfr_pkg::COND_FRAME_OK:  cond_hit = status.frame_ok;
         rcsfr_pkg::COND_RSP_FREE:  cond_hit = status.rsp_free;
         rcsfr_pkg::COND_CHAN_LAST: cond_hit = status.chan_last;
         default:                   cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? uword.target_true : uword.target_false;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= rcsfr_pkg::STEP_RX;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### hdl/rcsfr_datapath.sv
module rcsfr_datapath #(
   parameter int unsigned CHANNEL_COUNT = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  rcsfr_pkg::ctl_type                  ctl,
   output rcsfr_pkg::status_type               status,
   input  logic                                req_tvalid,
   input  logic [rcsfr_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                                csr_tvalid,
   input  logic                                csr_index,
   input  logic [rcsfr_pkg::BYTE_W-1:0]        csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcsfr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);

   localparam logic [rcsfr_pkg::CHAN_W-1:0] CHAN_LAST = rcsfr_pkg::CHAN_W'(CHANNEL_COUNT);

   logic [rcsfr_pkg::BYTE_W-1:0] hdr0_ff, hdr1_ff;
   logic [rcsfr_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [rcsfr_pkg::WORD_W-1:0] sum_ff, sum_in;
   logic [rcsfr_pkg::BYTE_W-1:0] lo_ff;
   logic [rcsfr_pkg::CHAN_W-1:0] chan_ff;
   logic                         rsp_valid_ff;
   logic [rcsfr_pkg::CHAN_W-1:0] rsp_num_ff;
   logic [rcsfr_pkg::WORD_W-1:0] rsp_value_ff;
   logic                         rsp_last_ff;
   logic [rcsfr_pkg::WORD_W-1:0] ram_rdata;

   logic rx_fire, hunt_drop, hdr_bad, take, frame_end;

   assign rx_fire   = req_tvalid && ctl.req_ready;
   assign hunt_drop = (pos_ff == '0) && (req_tdata != hdr0_ff);
   assign hdr_bad   = (pos_ff == rcsfr_pkg::POS_W'(1)) && (req_tdata != hdr1_ff);
   assign take      = rx_fire && !hunt_drop && !hdr_bad;
   assign frame_end = take && (pos_ff == rcsfr_pkg::POS_LAST);

   assign status.frame_ok  = frame_end && ({req_tdata, lo_ff} == sum_ff);
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;
   assign status.chan_last = (chan_ff == CHAN_LAST);

   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      if (rx_fire && hdr_bad) begin
         pos_in = '0;
         sum_in = rcsfr_pkg::SUM_INIT;
      end else if (frame_end) begin
         pos_in = '0;
         sum_in = rcsfr_pkg::SUM_INIT;
      end else if (take) begin
         pos_in = pos_ff + rcsfr_pkg::POS_W'(1);
         if (pos_ff < rcsfr_pkg::SUM_LEN) begin
            sum_in = sum_ff - {{(rcsfr_pkg::WORD_W-rcsfr_pkg::BYTE_W){1'b0}}, req_tdata};
         end
      end
   end

   // Bytes pair into little-endian words; word k holds channel k.
   rcsfr_ram #(
      .WIDTH(rcsfr_pkg::WORD_W),
      .DEPTH(rcsfr_pkg::FRAME_WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (take && pos_ff[0]),
      .wr_addr(pos_ff[rcsfr_pkg::POS_W-1:1]),
      .wr_data({req_tdata, lo_ff}),
      .rd_addr(chan_ff),
      .rd_data(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr0_ff      <= rcsfr_pkg::HDR0_RESET;
         hdr1_ff      <= rcsfr_pkg::HDR1_RESET;
         pos_ff       <= '0;
         sum_ff       <= rcsfr_pkg::SUM_INIT;
         chan_ff      <= rcsfr_pkg::CHAN_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_tvalid) begin
            case (rcsfr_pkg::csr_index_type'(csr_index))
               rcsfr_pkg::CSR_HEADER_FIRST:  hdr0_ff <= csr_wdata;
               rcsfr_pkg::CSR_HEADER_SECOND: hdr1_ff <= csr_wdata;
               default: ;
            endcase
         end
         pos_ff <= pos_in;
         sum_ff <= sum_in;
         if (ctl.chan_init) begin
            chan_ff <= rcsfr_pkg::CHAN_W'(1);
         end else if (ctl.rsp_load) begin
            chan_ff <= chan_ff + rcsfr_pkg::CHAN_W'(1);
         end
         if (ctl.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && !pos_ff[0]) begin
         lo_ff <= req_tdata;
      end
      if (ctl.rsp_load) begin
         rsp_num_ff   <= chan_ff;
         rsp_value_ff <= ram_rdata;
         rsp_last_ff  <= status.chan_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(rcsfr_pkg::RSP_DATA_W-rcsfr_pkg::WORD_W-rcsfr_pkg::CHAN_W){1'b0}},
                        rsp_value_ff, rsp_num_ff};

endmodule

### hdl/rcsfr_checker.sv
`include "rc_serial_frame_receiver_macros.svh"

module rcsfr_checker #(
   parameter int unsigned CHANNEL_COUNT = 14
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        csr_tvalid,
   input logic        csr_tready,
   input logic        csr_index,
   input logic [7:0]  csr_wdata
);

   localparam logic [3:0] CHAN_LAST = 4'(CHANNEL_COUNT);

   logic unused_ok;
   assign unused_ok = ^{req_tvalid, req_tdata, csr_tvalid, csr_tready, csr_index, csr_wdata};

   `RCSFR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   `RCSFR_ASSERT_NOW(a_chan_range, clock, reset, rsp_tvalid, (rsp_tdata[3:0] != 4'd0) && (rsp_tdata[3:0] <= CHAN_LAST) && (rsp_tdata[23:20] == 4'd0))

   `RCSFR_ASSERT_NOW(a_last_mark, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[3:0] == CHAN_LAST))

   `RCSFR_ASSERT_NEXT(a_readout_busy, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready)

endmodule

bind rc_serial_frame_receiver rcsfr_checker #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_checker (.*);
